>>> hdl/multilevel_feedback_thread_scheduler_macros.svh
// Assertion macros shared by the scheduler checker.
// Depends on nothing; include with the bare file name.
`ifndef MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_MACROS_SVH

// ante implies cons in the same cycle
`define MFTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define MFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mfts_pkg.sv
// Types, codes and class tables of the thread scheduler.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package mfts_pkg;

    localparam int PRIORITY_LEVELS = 64;
    localparam int MAX_THREADS     = 64;
    localparam int LVL_W           = $clog2(PRIORITY_LEVELS);
    localparam int TID_W           = $clog2(MAX_THREADS);

    localparam logic [2:0] OP_ENTER   = 3'd0;
    localparam logic [2:0] OP_READY   = 3'd1;
    localparam logic [2:0] OP_BLOCK   = 3'd2;
    localparam logic [2:0] OP_LEAVE   = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_RESCHED = 3'd5;
    localparam logic [2:0] OP_ENABLE  = 3'd6;
    localparam logic [2:0] OP_DISABLE = 3'd7;

    localparam logic [2:0] CLS_IDLE   = 3'd0;
    localparam logic [2:0] CLS_NORMAL = 3'd1;
    localparam logic [2:0] CLS_DRIVER = 3'd2;
    localparam logic [2:0] CLS_RT     = 3'd3;
    localparam logic [2:0] CLS_RT_DRV = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_CLASS   = 2'd1;
    localparam logic [1:0] ST_RESCHED_OFF = 2'd2;

    localparam logic CFG_UNIT = 1'b0;
    localparam logic CFG_TICK = 1'b1;

    localparam logic [7:0]  UNIT_RESET   = 8'd20;
    localparam logic [7:0]  TICK_RESET   = 8'd10;
    localparam logic [15:0] INF_QUANTUM  = 16'hFFFF;
    localparam logic [15:0] QUANTUM_CAP  = 16'hFFFE;

    localparam logic [1:0] TS_KEEP = 2'd0;
    localparam logic [1:0] TS_TID  = 2'd1;
    localparam logic [1:0] TS_CUR  = 2'd2;
    localparam logic [1:0] TS_PICK = 2'd3;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [TID_W-1:0] thread_id;
        logic [2:0]       new_class;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             switched;
        logic [TID_W-1:0] running_thread;
        logic [LVL_W-1:0] running_priority;
        logic [15:0]      quantum_remaining;
    } result_t;

    typedef struct packed {
        logic       ld_in;
        logic [1:0] t_sel;
        logic       rd_thr;
        logic       rd_lvl;
        logic       rd_pick;
        logic       do_rem;
        logic       do_ins;
        logic       do_wr;
        logic       do_chg;
        logic       chg_up;
        logic       save_was;
        logic       q_sub;
        logic       q_zero;
        logic       q_set;
        logic       en_set;
        logic       en_clr;
        logic       st_bad;
        logic       st_off;
        logic       out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       cls_bad;
        logic       en;
        logic       was;
        logic       preempt;
        logic       q_inf;
        logic       q_gt;
        logic       any_ne;
        logic       out_busy;
    } ctl_status_t;

    function automatic logic [LVL_W-1:0] class_max(input logic [2:0] cls);
        logic [LVL_W-1:0] r;
        unique case (cls)
            CLS_NORMAL: r = LVL_W'(15);
            CLS_DRIVER: r = LVL_W'(31);
            CLS_RT:     r = LVL_W'(47);
            CLS_RT_DRV: r = LVL_W'(63);
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [LVL_W-1:0] class_min(input logic [2:0] cls);
        logic [LVL_W-1:0] r;
        unique case (cls)
            CLS_NORMAL: r = LVL_W'(1);
            CLS_DRIVER: r = LVL_W'(16);
            CLS_RT:     r = LVL_W'(32);
            CLS_RT_DRV: r = LVL_W'(48);
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/multilevel_feedback_thread_scheduler.sv
// Events are handled one at a time: cmd_ready is high only while the sequencer is idle,
// so no new event is accepted until the last one has loaded its result. A result may wait
// in the output register while the next event runs.
// Reset (async, active low): level 0 holds thread 0 running with infinite quantum,
// scheduling disabled, unit quantum 20, tick length 10; no clearing pass.
`timescale 1ns / 1ps

module multilevel_feedback_thread_scheduler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mfts_pkg::cmd_t     cmd,
    output logic               result_valid,
    input  logic               result_ready,
    output mfts_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);

    mfts_pkg::ctl_cmd_t    ctl;
    mfts_pkg::ctl_status_t sts;

    mfts_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    mfts_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .ctl          (ctl),
        .sts          (sts)
    );

endmodule

>>> hdl/mfts_datapath.sv
// Scheduler datapath: ready list memories, thread table, quantum and result register.
// Depends on mfts_pkg; driven by mfts_controller.
`timescale 1ns / 1ps

module mfts_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mfts_pkg::cmd_t         cmd,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_data,
    output mfts_pkg::result_t      result,
    output logic                   result_valid,
    input  logic                   result_ready,
    input  mfts_pkg::ctl_cmd_t     ctl,
    output mfts_pkg::ctl_status_t  sts
);

    localparam int LW = mfts_pkg::LVL_W;
    localparam int TW = mfts_pkg::TID_W;
    localparam int NL = mfts_pkg::PRIORITY_LEVELS;
    localparam int NT = mfts_pkg::MAX_THREADS;

    logic [2:0]    op_reg;
    logic [TW-1:0] tid_reg;
    logic [2:0]    cls_in_reg;
    logic [TW-1:0] t_reg;
    logic [TW-1:0] running_reg;
    logic [15:0]   quantum_reg;
    logic          en_reg;
    logic [1:0]    status_reg;
    logic          switched_reg;
    logic          was_reg;
    logic [7:0]    unit_reg;
    logic [7:0]    tick_reg;
    logic [NL-1:0] nonempty_reg;
    logic [NT-1:0] queued_reg;
    logic [NT-1:0] tvalid_reg;
    logic          h0init_reg;
    logic          t0init_reg;
    mfts_pkg::result_t out_reg;
    logic          out_valid_reg;

    logic [LW+2:0] thr_mem [NT];
    logic [TW-1:0] head_mem [NL];
    logic [TW-1:0] tail_mem [NL];
    logic [TW-1:0] next_mem [NT];
    logic [TW-1:0] prev_mem [NT];

    logic [LW+2:0] thr_q;
    logic          thr_v_q;
    logic [TW-1:0] head_q;
    logic [TW-1:0] tail_q;
    logic          head_z_q;
    logic          tail_z_q;
    logic [TW-1:0] nx_q;
    logic [TW-1:0] pv_q;

    logic [2:0]    cls_eff;
    logic [LW-1:0] pri_eff;
    logic [LW-1:0] lv;
    logic [TW-1:0] hd;
    logic [TW-1:0] tl;
    logic [LW-1:0] h_lvl;
    logic          any_ne;
    logic [LW-1:0] hr_addr;

    logic          head_we, tail_we, next_we, prev_we, thr_we, ne_set, ne_clr;
    logic [LW-1:0] head_wa, tail_wa;
    logic [TW-1:0] head_wd, tail_wd, next_wa, next_wd, prev_wa, prev_wd;
    logic [LW+2:0] thr_wd;
    logic          rem_go, ins_go;

    logic signed [7:0] p_s;
    logic [LW-1:0]     newp;
    logic signed [7:0] q_n;
    logic [14:0]       q_prod;
    logic [15:0]       qf;

    assign cls_eff = thr_v_q ? thr_q[LW+2:LW] : mfts_pkg::CLS_IDLE;
    assign pri_eff = thr_v_q ? thr_q[LW-1:0] : '0;
    assign lv      = pri_eff;
    assign hd      = head_z_q ? '0 : head_q;
    assign tl      = tail_z_q ? '0 : tail_q;
    assign any_ne  = |nonempty_reg;
    assign hr_addr = ctl.rd_pick ? h_lvl : lv;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        h_lvl = '0;
        for (int i = 0; i < NL; i++)
        begin
            if (nonempty_reg[i])
            begin
                h_lvl = LW'(i);
            end
        end
    end

    always_comb
    begin
        p_s = $signed({2'b00, pri_eff}) + (ctl.chg_up ? 8'sd1 : -8'sd1);
        if (cls_eff == mfts_pkg::CLS_IDLE || cls_eff > mfts_pkg::CLS_RT_DRV)
        begin
            newp = '0;
        end
        else if (p_s > $signed({2'b00, mfts_pkg::class_max(cls_eff)}))
        begin
            newp = mfts_pkg::class_max(cls_eff);
        end
        else if (p_s < $signed({2'b00, mfts_pkg::class_min(cls_eff)}))
        begin
            newp = mfts_pkg::class_min(cls_eff);
        end
        else
        begin
            newp = p_s[LW-1:0];
        end
    end

    always_comb
    begin
        q_n = $signed({2'b00, mfts_pkg::class_max(cls_eff)}) - $signed({2'b00, pri_eff})
              + 8'sd1;
        if (q_n < 8'sd1)
        begin
            q_n = 8'sd1;
        end
        q_prod = 15'(q_n[6:0]) * 15'(unit_reg);
        if (cls_eff == mfts_pkg::CLS_IDLE || cls_eff > mfts_pkg::CLS_RT_DRV)
        begin
            qf = mfts_pkg::INF_QUANTUM;
        end
        else if ({1'b0, q_prod} > mfts_pkg::QUANTUM_CAP)
        begin
            qf = mfts_pkg::QUANTUM_CAP;
        end
        else
        begin
            qf = {1'b0, q_prod};
        end
    end

    always_comb
    begin
        rem_go  = ctl.do_rem && queued_reg[t_reg];
        ins_go  = ctl.do_ins && !queued_reg[t_reg];
        head_we = 1'b0;
        tail_we = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        ne_set  = 1'b0;
        ne_clr  = 1'b0;
        head_wa = lv;
        tail_wa = lv;
        head_wd = t_reg;
        tail_wd = t_reg;
        next_wa = pv_q;
        next_wd = nx_q;
        prev_wa = nx_q;
        prev_wd = pv_q;
        if (rem_go)
        begin
            priority if (hd == t_reg && tl == t_reg)
            begin
                ne_clr = 1'b1;
            end
            else if (hd == t_reg)
            begin
                head_we = 1'b1;
                head_wd = nx_q;
            end
            else if (tl == t_reg)
            begin
                tail_we = 1'b1;
                tail_wd = pv_q;
            end
            else
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
        end
        else if (ins_go)
        begin
            tail_we = 1'b1;
            if (nonempty_reg[lv])
            begin
                next_we = 1'b1;
                next_wa = tl;
                next_wd = t_reg;
                prev_we = 1'b1;
                prev_wa = t_reg;
                prev_wd = tl;
            end
            else
            begin
                head_we = 1'b1;
                ne_set  = 1'b1;
            end
        end
        thr_we = ctl.do_wr || ctl.do_chg;
        thr_wd = ctl.do_wr ? {cls_in_reg, mfts_pkg::class_max(cls_in_reg)} : {cls_eff, newp};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_in)
        begin
            op_reg     <= cmd.opcode;
            tid_reg    <= cmd.thread_id;
            cls_in_reg <= cmd.new_class;
        end
        if (ctl.rd_thr)
        begin
            thr_q   <= thr_mem[t_reg];
            thr_v_q <= tvalid_reg[t_reg];
        end
        if (ctl.rd_lvl || ctl.rd_pick)
        begin
            head_q   <= head_mem[hr_addr];
            head_z_q <= h0init_reg && (hr_addr == '0);
        end
        if (ctl.rd_lvl)
        begin
            tail_q   <= tail_mem[lv];
            tail_z_q <= t0init_reg && (lv == '0);
            nx_q     <= next_mem[t_reg];
            pv_q     <= prev_mem[t_reg];
        end
        if (ctl.save_was)
        begin
            was_reg <= queued_reg[t_reg];
        end
        unique case (ctl.t_sel)
            mfts_pkg::TS_TID:  t_reg <= tid_reg;
            mfts_pkg::TS_CUR:  t_reg <= running_reg;
            mfts_pkg::TS_PICK: t_reg <= hd;
            default:           t_reg <= t_reg;
        endcase
        if (ctl.out_load)
        begin
            out_reg <= '{status: status_reg, switched: switched_reg,
                         running_thread: running_reg, running_priority: pri_eff,
                         quantum_remaining: quantum_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (thr_we)
        begin
            thr_mem[t_reg] <= thr_wd;
        end
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        if (tail_we)
        begin
            tail_mem[tail_wa] <= tail_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            quantum_reg   <= mfts_pkg::INF_QUANTUM;
            en_reg        <= 1'b0;
            status_reg    <= mfts_pkg::ST_OK;
            switched_reg  <= 1'b0;
            unit_reg      <= mfts_pkg::UNIT_RESET;
            tick_reg      <= mfts_pkg::TICK_RESET;
            nonempty_reg  <= NL'(1);
            queued_reg    <= NT'(1);
            tvalid_reg    <= '0;
            h0init_reg    <= 1'b1;
            t0init_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mfts_pkg::CFG_UNIT: unit_reg <= cfg_data;
                    mfts_pkg::CFG_TICK: tick_reg <= cfg_data;
                    default:            unit_reg <= unit_reg;
                endcase
            end
            if (ctl.ld_in)
            begin
                status_reg   <= mfts_pkg::ST_OK;
                switched_reg <= 1'b0;
            end
            if (ctl.st_bad)
            begin
                status_reg <= mfts_pkg::ST_BAD_CLASS;
            end
            if (ctl.st_off)
            begin
                status_reg <= mfts_pkg::ST_RESCHED_OFF;
            end
            if (ctl.en_set)
            begin
                en_reg <= 1'b1;
            end
            if (ctl.en_clr)
            begin
                en_reg <= 1'b0;
            end
            if (ctl.q_sub)
            begin
                quantum_reg <= quantum_reg - {8'h00, tick_reg};
            end
            if (ctl.q_zero)
            begin
                quantum_reg <= '0;
            end
            if (ctl.q_set)
            begin
                quantum_reg <= qf;
                if (t_reg != running_reg)
                begin
                    running_reg  <= t_reg;
                    en_reg       <= 1'b0;
                    switched_reg <= 1'b1;
                end
            end
            if (thr_we)
            begin
                tvalid_reg[t_reg] <= 1'b1;
            end
            if (rem_go)
            begin
                queued_reg[t_reg] <= 1'b0;
            end
            if (ins_go)
            begin
                queued_reg[t_reg] <= 1'b1;
            end
            if (ne_set)
            begin
                nonempty_reg[lv] <= 1'b1;
            end
            if (ne_clr)
            begin
                nonempty_reg[lv] <= 1'b0;
            end
            if (head_we && head_wa == '0)
            begin
                h0init_reg <= 1'b0;
            end
            if (tail_we && tail_wa == '0)
            begin
                t0init_reg <= 1'b0;
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    assign sts.op       = op_reg;
    assign sts.cls_bad  = cls_in_reg > mfts_pkg::CLS_RT_DRV;
    assign sts.en       = en_reg;
    assign sts.was      = was_reg;
    assign sts.preempt  = any_ne && (h_lvl > pri_eff);
    assign sts.q_inf    = quantum_reg == mfts_pkg::INF_QUANTUM;
    assign sts.q_gt     = quantum_reg > {8'h00, tick_reg};
    assign sts.any_ne   = any_ne;
    assign sts.out_busy = out_valid_reg && !result_ready;

endmodule

>>> hdl/mfts_controller.sv
// Scheduler sequencer: steps each event through list, table and quantum updates.
// Depends on mfts_pkg; drives mfts_datapath.
`timescale 1ns / 1ps

module mfts_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  mfts_pkg::ctl_status_t  sts,
    output mfts_pkg::ctl_cmd_t     ctl
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_LD0     = 5'd2;
    localparam logic [4:0] S_LD1     = 5'd3;
    localparam logic [4:0] S_E_REM   = 5'd4;
    localparam logic [4:0] S_E_WR    = 5'd5;
    localparam logic [4:0] S_INS_FIN = 5'd6;
    localparam logic [4:0] S_REM_FIN = 5'd7;
    localparam logic [4:0] S_B_REM   = 5'd8;
    localparam logic [4:0] S_B_CHG   = 5'd9;
    localparam logic [4:0] S_T_DEC   = 5'd10;
    localparam logic [4:0] S_P_REM   = 5'd11;
    localparam logic [4:0] S_P_INS   = 5'd12;
    localparam logic [4:0] S_X_REM   = 5'd13;
    localparam logic [4:0] S_X_CHG   = 5'd14;
    localparam logic [4:0] S_X_INS   = 5'd15;
    localparam logic [4:0] S_SEL     = 5'd16;
    localparam logic [4:0] S_PICK    = 5'd17;
    localparam logic [4:0] S_PICK1   = 5'd18;
    localparam logic [4:0] S_QSET    = 5'd19;
    localparam logic [4:0] S_FIN     = 5'd20;
    localparam logic [4:0] S_OUT     = 5'd21;

    logic [4:0] state_reg, state_next;
    logic [4:0] ret_reg, ret_next;

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.ld_in  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.op)
                    mfts_pkg::OP_ENTER:
                    begin
                        if (sts.cls_bad)
                        begin
                            ctl.st_bad = 1'b1;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ctl.t_sel  = mfts_pkg::TS_TID;
                            ret_next   = S_E_REM;
                            state_next = S_LD0;
                        end
                    end
                    mfts_pkg::OP_READY:
                    begin
                        ctl.t_sel  = mfts_pkg::TS_TID;
                        ret_next   = S_INS_FIN;
                        state_next = S_LD0;
                    end
                    mfts_pkg::OP_BLOCK:
                    begin
                        ctl.t_sel  = mfts_pkg::TS_TID;
                        ret_next   = S_B_REM;
                        state_next = S_LD0;
                    end
                    mfts_pkg::OP_LEAVE:
                    begin
                        ctl.t_sel  = mfts_pkg::TS_TID;
                        ret_next   = S_REM_FIN;
                        state_next = S_LD0;
                    end
                    mfts_pkg::OP_TICK:
                    begin
                        ctl.t_sel  = mfts_pkg::TS_CUR;
                        ret_next   = S_T_DEC;
                        state_next = S_LD0;
                    end
                    mfts_pkg::OP_RESCHED:
                    begin
                        if (!sts.en)
                        begin
                            ctl.st_off = 1'b1;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SEL;
                        end
                    end
                    mfts_pkg::OP_ENABLE:
                    begin
                        ctl.en_set = 1'b1;
                        state_next = S_FIN;
                    end
                    default:
                    begin
                        ctl.en_clr = 1'b1;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_LD0:
            begin
                ctl.rd_thr = 1'b1;
                state_next = S_LD1;
            end
            S_LD1:
            begin
                ctl.rd_lvl = 1'b1;
                state_next = ret_reg;
            end
            S_E_REM:
            begin
                ctl.do_rem = 1'b1;
                state_next = S_E_WR;
            end
            S_E_WR:
            begin
                ctl.do_wr  = 1'b1;
                ret_next   = S_INS_FIN;
                state_next = S_LD0;
            end
            S_INS_FIN:
            begin
                ctl.do_ins = 1'b1;
                state_next = S_FIN;
            end
            S_REM_FIN:
            begin
                ctl.do_rem = 1'b1;
                state_next = S_FIN;
            end
            S_B_REM:
            begin
                ctl.do_rem = 1'b1;
                state_next = S_B_CHG;
            end
            S_B_CHG:
            begin
                ctl.do_chg = 1'b1;
                ctl.chg_up = 1'b1;
                state_next = S_FIN;
            end
            S_T_DEC:
            begin
                priority if (sts.preempt)
                begin
                    ctl.save_was = 1'b1;
                    state_next   = S_P_REM;
                end
                else if (sts.q_inf)
                begin
                    state_next = S_FIN;
                end
                else if (sts.q_gt)
                begin
                    ctl.q_sub  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.q_zero   = 1'b1;
                    ctl.save_was = 1'b1;
                    state_next   = S_X_REM;
                end
            end
            S_P_REM:
            begin
                ctl.do_rem = 1'b1;
                if (sts.was)
                begin
                    ret_next   = S_P_INS;
                    state_next = S_LD0;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end
            S_P_INS:
            begin
                ctl.do_ins = 1'b1;
                state_next = S_PICK;
            end
            S_X_REM:
            begin
                ctl.do_rem = 1'b1;
                state_next = S_X_CHG;
            end
            S_X_CHG:
            begin
                ctl.do_chg = 1'b1;
                if (sts.was)
                begin
                    ret_next   = S_X_INS;
                    state_next = S_LD0;
                end
                else
                begin
                    state_next = S_SEL;
                end
            end
            S_X_INS:
            begin
                ctl.do_ins = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                priority if (sts.any_ne)
                begin
                    state_next = S_PICK;
                end
                else if (sts.op == mfts_pkg::OP_TICK)
                begin
                    ctl.t_sel  = mfts_pkg::TS_CUR;
                    ret_next   = S_QSET;
                    state_next = S_LD0;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_PICK:
            begin
                ctl.rd_pick = 1'b1;
                state_next  = S_PICK1;
            end
            S_PICK1:
            begin
                ctl.t_sel  = mfts_pkg::TS_PICK;
                ret_next   = S_QSET;
                state_next = S_LD0;
            end
            S_QSET:
            begin
                ctl.q_set  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                ctl.t_sel  = mfts_pkg::TS_CUR;
                ret_next   = S_OUT;
                state_next = S_LD0;
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

>>> hdl/mfts_checker.sv
// Port-level checks of the scheduler, bound to the top level.
// Depends on mfts_pkg and multilevel_feedback_thread_scheduler_macros.svh.
`timescale 1ns / 1ps
`include "multilevel_feedback_thread_scheduler_macros.svh"

module mfts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               result_valid,
    input logic               result_ready,
    input mfts_pkg::result_t  result
);

    `MFTS_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "result word dropped or changed while stalled")
    `MFTS_ASSERT_NEXT(a_one_event, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "command word accepted while an event is in progress")
    `MFTS_ASSERT_NOW(a_status_code, clk, rst_n, result_valid, result.status != 2'd3, "undefined status code")
    `MFTS_ASSERT_NOW(a_switch_ok, clk, rst_n, result_valid && result.switched, result.status == mfts_pkg::ST_OK, "switch reported with error status")

endmodule

bind multilevel_feedback_thread_scheduler mfts_checker u_mfts_checker (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the multilevel feedback thread scheduler.
// Depends on mfts_pkg and the scheduler RTL; predicts every result in-bench.
// Covers directed events, config sweeps, then random traffic under varied idling.
`timescale 1ns / 1ps

module tb_top;
    import mfts_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 30;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cmd_valid = 1'b0;
    logic    cmd_ready;
    cmd_t    cmd = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic    cfg_index = 1'b0;
    logic [7:0] cfg_data = '0;

    int send_idle = 0;
    int recv_idle = 0;
    int errors = 0;
    int events_sent = 0;
    int results_seen = 0;
    int cycles = 0;
    result_t pending_results[$];

    // scheduler shadow state
    bit [63:0] lvl_busy;
    bit [5:0]  lvl_head[64];
    bit [5:0]  lvl_tail[64];
    bit [5:0]  succ[64];
    bit [5:0]  pred[64];
    bit [5:0]  prio[64];
    bit [2:0]  tclass[64];
    bit        listed[64];
    bit [5:0]  run_tid;
    bit [15:0] slice_left;
    bit        sched_on;
    bit [7:0]  unit_q;
    bit [7:0]  tick_len;

    always #2 clk = ~clk;

    multilevel_feedback_thread_scheduler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic int band_top(bit [2:0] c);
        case (c)
            CLS_NORMAL: return 15;
            CLS_DRIVER: return 31;
            CLS_RT:     return 47;
            CLS_RT_DRV: return 63;
            default:    return 0;
        endcase
    endfunction

    function automatic int band_bottom(bit [2:0] c);
        case (c)
            CLS_NORMAL: return 1;
            CLS_DRIVER: return 16;
            CLS_RT:     return 32;
            CLS_RT_DRV: return 48;
            default:    return 0;
        endcase
    endfunction

    function automatic void enqueue_thread(int t);
        int lv;
        lv = prio[t];
        if (listed[t])
            return;
        if (lvl_busy[lv]) begin
            succ[lvl_tail[lv]] = t;
            pred[t] = lvl_tail[lv];
        end
        else begin
            lvl_head[lv] = t;
            lvl_busy[lv] = 1'b1;
            pred[t] = t;
        end
        succ[t] = t;
        lvl_tail[lv] = t;
        listed[t] = 1'b1;
    endfunction

    function automatic void dequeue_thread(int t);
        int lv;
        int nx;
        int pv;
        lv = prio[t];
        if (!listed[t])
            return;
        nx = succ[t];
        pv = pred[t];
        if (lvl_head[lv] == t && lvl_tail[lv] == t)
            lvl_busy[lv] = 1'b0;
        else if (lvl_head[lv] == t)
            lvl_head[lv] = nx;
        else if (lvl_tail[lv] == t)
            lvl_tail[lv] = pv;
        else begin
            succ[pv] = nx;
            pred[nx] = pv;
        end
        listed[t] = 1'b0;
    endfunction

    function automatic int top_level();
        for (int i = 63; i >= 0; i--)
            if (lvl_busy[i])
                return i;
        return -1;
    endfunction

    function automatic bit [15:0] slice_for(int t);
        int n;
        int qq;
        if (tclass[t] == CLS_IDLE || tclass[t] > CLS_RT_DRV)
            return INF_QUANTUM;
        n = band_top(tclass[t]) - prio[t] + 1;
        if (n < 1)
            n = 1;
        qq = n * unit_q;
        if (qq > QUANTUM_CAP)
            qq = QUANTUM_CAP;
        return qq[15:0];
    endfunction

    function automatic void shift_priority(int t, int d);
        int p;
        p = prio[t] + d;
        if (tclass[t] == CLS_IDLE || tclass[t] > CLS_RT_DRV)
            p = 0;
        else begin
            if (p > band_top(tclass[t]))
                p = band_top(tclass[t]);
            if (p < band_bottom(tclass[t]))
                p = band_bottom(tclass[t]);
        end
        prio[t] = p;
    endfunction

    function automatic void dispatch(int t, ref bit sw);
        run_tid = t;
        slice_left = slice_for(t);
        sched_on = 1'b0;
        sw = 1'b1;
    endfunction

    function automatic void reset_scheduler();
        for (int i = 0; i < 64; i++) begin
            succ[i] = 0;
            pred[i] = 0;
            prio[i] = 0;
            tclass[i] = CLS_IDLE;
            listed[i] = 1'b0;
            lvl_head[i] = 0;
            lvl_tail[i] = 0;
        end
        lvl_busy = '0;
        enqueue_thread(0);
        run_tid = 0;
        slice_left = INF_QUANTUM;
        sched_on = 1'b0;
        unit_q = UNIT_RESET;
        tick_len = TICK_RESET;
    endfunction

    function automatic result_t schedule_event(cmd_t c);
        result_t r;
        bit [1:0] st;
        bit sw;
        int cur;
        int tid;
        int h;
        int nx;
        bit was;
        st = ST_OK;
        sw = 1'b0;
        cur = run_tid;
        tid = c.thread_id;
        case (c.opcode)
            OP_ENTER: begin
                if (c.new_class > CLS_RT_DRV)
                    st = ST_BAD_CLASS;
                else begin
                    dequeue_thread(tid);
                    tclass[tid] = c.new_class;
                    prio[tid] = band_top(c.new_class);
                    enqueue_thread(tid);
                end
            end
            OP_READY: enqueue_thread(tid);
            OP_BLOCK: begin
                dequeue_thread(tid);
                shift_priority(tid, 1);
            end
            OP_LEAVE: dequeue_thread(tid);
            OP_TICK: begin
                h = top_level();
                if (h >= 0 && h > prio[cur]) begin
                    nx = lvl_head[h];
                    if (listed[cur]) begin
                        dequeue_thread(cur);
                        enqueue_thread(cur);
                    end
                    if (nx != cur)
                        dispatch(nx, sw);
                end
                else if (slice_left == INF_QUANTUM) begin
                end
                else if (slice_left > tick_len)
                    slice_left = slice_left - tick_len;
                else begin
                    slice_left = 0;
                    was = listed[cur];
                    dequeue_thread(cur);
                    shift_priority(cur, -1);
                    if (was)
                        enqueue_thread(cur);
                    h = top_level();
                    if (h >= 0 && lvl_head[h] != cur)
                        dispatch(lvl_head[h], sw);
                    else
                        slice_left = slice_for(cur);
                end
            end
            OP_RESCHED: begin
                if (!sched_on)
                    st = ST_RESCHED_OFF;
                else begin
                    h = top_level();
                    if (h >= 0) begin
                        nx = lvl_head[h];
                        if (nx != cur)
                            dispatch(nx, sw);
                        else
                            slice_left = slice_for(cur);
                    end
                end
            end
            OP_ENABLE: sched_on = 1'b1;
            default:   sched_on = 1'b0;
        endcase
        r.status = st;
        r.switched = sw;
        r.running_thread = run_tid;
        r.running_priority = prio[run_tid];
        r.quantum_remaining = slice_left;
        return r;
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            result_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk) begin
        result_t want;
        if (rst_n && result_valid && result_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %p", result);
                errors++;
            end
            else begin
                want = pending_results.pop_front();
                if (result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    errors++;
                end
                if (result.switched !== want.switched) begin
                    $error("switched: expected %0d, got %0d", want.switched, result.switched);
                    errors++;
                end
                if (result.running_thread !== want.running_thread) begin
                    $error("running_thread: expected %0d, got %0d",
                           want.running_thread, result.running_thread);
                    errors++;
                end
                if (result.running_priority !== want.running_priority) begin
                    $error("running_priority: expected %0d, got %0d",
                           want.running_priority, result.running_priority);
                    errors++;
                end
                if (result.quantum_remaining !== want.quantum_remaining) begin
                    $error("quantum_remaining: expected %0d, got %0d",
                           want.quantum_remaining, result.quantum_remaining);
                    errors++;
                end
            end
        end
    end

    task automatic send_event(bit [2:0] op, bit [5:0] tid, bit [2:0] c);
        cmd_t w;
        w.opcode = op;
        w.thread_id = tid;
        w.new_class = c;
        @(posedge clk);
        while ($urandom_range(99) < send_idle)
            @(posedge clk);
        cmd_valid <= 1'b1;
        cmd <= w;
        do
            @(posedge clk);
        while (!cmd_ready);
        pending_results.push_back(schedule_event(w));
        events_sent++;
        cmd_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(bit idx, bit [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_UNIT)
            unit_q = val;
        else
            tick_len = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_event(OP_RESCHED, 0, CLS_IDLE);
        send_event(OP_ENTER, 63, CLS_RT_DRV);
        send_event(OP_ENTER, 5, 3'd5);
        send_event(OP_ENTER, 5, 3'd6);
        send_event(OP_ENTER, 5, 3'd7);
        send_event(OP_TICK, 0, CLS_IDLE);
        send_event(OP_ENTER, 1, CLS_NORMAL);
        send_event(OP_READY, 1, CLS_IDLE);
        send_event(OP_ENTER, 2, CLS_NORMAL);
        send_event(OP_TICK, 0, CLS_IDLE);
        send_event(OP_TICK, 0, CLS_IDLE);
        send_event(OP_TICK, 0, CLS_IDLE);
        send_event(OP_BLOCK, 63, CLS_IDLE);
        send_event(OP_BLOCK, 63, CLS_IDLE);
        send_event(OP_READY, 63, CLS_IDLE);
        send_event(OP_LEAVE, 63, CLS_IDLE);
        send_event(OP_TICK, 0, CLS_IDLE);
        send_event(OP_ENTER, 3, CLS_DRIVER);
        send_event(OP_ENABLE, 0, CLS_IDLE);
        send_event(OP_RESCHED, 0, CLS_IDLE);
        send_event(OP_ENABLE, 0, CLS_IDLE);
        send_event(OP_LEAVE, 0, CLS_IDLE);
        send_event(OP_RESCHED, 0, CLS_IDLE);
        send_event(OP_DISABLE, 0, CLS_IDLE);
        send_event(OP_ENTER, 4, CLS_RT);
    endtask

    task automatic test_config_extremes();
        write_register(CFG_UNIT, 8'd1);
        write_register(CFG_TICK, 8'd255);
        repeat (4) send_event(OP_TICK, 0, CLS_IDLE);
        send_event(OP_ENTER, 7, CLS_NORMAL);
        send_event(OP_TICK, 0, CLS_IDLE);
        wait_drained();
        write_register(CFG_UNIT, 8'd255);
        write_register(CFG_TICK, 8'd1);
        send_event(OP_ENTER, 8, CLS_RT_DRV);
        repeat (4) send_event(OP_TICK, 0, CLS_IDLE);
        wait_drained();
    endtask

    task automatic test_random_events(int count);
        int r;
        bit [2:0] op;
        bit [5:0] tid;
        bit [2:0] c;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 20)      op = OP_ENTER;
            else if (r < 30) op = OP_READY;
            else if (r < 40) op = OP_BLOCK;
            else if (r < 48) op = OP_LEAVE;
            else if (r < 78) op = OP_TICK;
            else if (r < 88) op = OP_RESCHED;
            else if (r < 96) op = OP_ENABLE;
            else             op = OP_DISABLE;
            tid = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
            c = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4);
            send_event(op, tid, c);
        end
    endtask

    task automatic test_random_phase(int snd, int rcv, int count);
        wait_drained();
        write_register(CFG_UNIT, $urandom_range(1, 255));
        write_register(CFG_TICK, $urandom_range(1, 255));
        send_idle = snd;
        recv_idle = rcv;
        test_random_events(count / 2);
        wait_drained();
        write_register(CFG_UNIT, $urandom_range(1, 8));
        write_register(CFG_TICK, $urandom_range(1, 40));
        test_random_events(count - count / 2);
    endtask

    initial begin
        reset_scheduler();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 9;
        recv_idle = 79;
        test_directed();
        wait_drained();
        test_config_extremes();
        write_register(CFG_UNIT, UNIT_RESET);
        write_register(CFG_TICK, TICK_RESET);
        test_random_phase(9, 79, 400);
        test_random_phase(79, 9, 400);
        test_random_phase(0, 0, 400);
        wait_drained();
        $display("Ran %0d scheduler events, %0d result words checked, %0d mismatches.",
                 events_sent, results_seen, errors);
        $display("Covered directed cases, config extremes and three idling profiles.");
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
